// File: src/ccdfa_pkg.sv
// shared types, constants and divider step for the ccd line frame averager
`timescale 1ns / 1ps

package ccdfa_pkg;

	localparam int LINE_PIXELS = 4096;
	localparam int ADDR_W      = $clog2(LINE_PIXELS);
	localparam int SAMPLE_W    = 12;
	localparam int INDEX_W     = 12;
	localparam int VALUE_W     = 16;
	localparam int COUNT_W     = 4;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STAGES  = VALUE_W / DIV_BITS;

	localparam logic [VALUE_W-1:0] SUM_MAX       = {VALUE_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(1);

	typedef enum logic [1:0] {
		ROLE_PASS   = 2'd0,
		ROLE_FIRST  = 2'd1,
		ROLE_MIDDLE = 2'd2,
		ROLE_LAST   = 2'd3
	} frame_role_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pixel_sample;
		logic [INDEX_W-1:0]  pixel_index;
		frame_role_t         frame_role;
	} in_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] pixel_value;
		logic [INDEX_W-1:0] pixel_position;
	} out_word_t;

	// one item inside the divider pipeline
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] work;      // dividend shifts out, quotient shifts in
		logic [COUNT_W-1:0] rem;
		logic [COUNT_W-1:0] divisor;
		logic [INDEX_W-1:0] position;
	} div_item_t;

	// one restoring division step: remainder stays below the divisor
	function automatic div_item_t div_step(div_item_t it);
		div_item_t        r;
		logic [COUNT_W:0] part;
		logic             qbit;
		r    = it;
		part = {r.rem, r.work[VALUE_W-1]};
		qbit = 1'b0;
		if (part >= {1'b0, r.divisor}) begin
			part = part - {1'b0, r.divisor};
			qbit = 1'b1;
		end
		r.rem  = part[COUNT_W-1:0];
		r.work = {r.work[VALUE_W-2:0], qbit};
		return r;
	endfunction

endpackage

// File: src/ccdfa_divider.sv
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps

module ccdfa_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  ccdfa_pkg::div_item_t  din,
	output ccdfa_pkg::div_item_t  dout
);
	import ccdfa_pkg::*;

	div_item_t stage_s [DIV_STAGES];
	div_item_t next_c  [DIV_STAGES];

	always_comb begin
		for (int s = 0; s < DIV_STAGES; s++) begin
			next_c[s] = (s == 0) ? din : stage_s[(s == 0) ? 0 : s - 1];
			for (int b = 0; b < DIV_BITS; b++) begin
				next_c[s] = div_step(next_c[s]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DIV_STAGES; s++) begin
				stage_s[s] <= '0;
			end
		end else if (adv) begin
			for (int s = 0; s < DIV_STAGES; s++) begin
				stage_s[s] <= next_c[s];
			end
		end
	end

	assign dout = stage_s[DIV_STAGES-1];

endmodule

// File: src/ccd_line_frame_averager_core.sv
// top level of the ccd line frame averager: accumulator memory, pipeline and output register
`timescale 1ns / 1ps

// Averages several exposures of a linear CCD line. One pixel word enters per cycle
// while in_stall is low. A pass-through word comes out unchanged; a first-exposure word
// overwrites the pixel's accumulator entry; a middle word adds to it (saturating at
// 65535); a last word adds, stores, and emits the sum divided by exposure_count
// (truncated, a count of zero divides by one). Indexes at or beyond the line length
// are ignored except for pass-through words. Sustained rate is one word per cycle
// while in_stall is low; an accepted word loads the memory read stage, then passes
// the saturating add with write-back, four divider stages of four quotient bits each,
// and the output register.
// All stages move together and freeze only when the output register holds a word,
// out_stall is high and a further result is ready behind it. Back-to-back words to
// the same pixel are handled by forwarding the write-back value. Accumulator
// content after reset is undefined until a first exposure writes it.
// exposure_count must only be written while the block is idle.

module ccd_line_frame_averager_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_wr_en,
	input  logic [ccdfa_pkg::COUNT_W-1:0]          cfg_wr_data,
	// input words
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  ccdfa_pkg::in_word_t                    in_word,
	// output words
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output ccdfa_pkg::out_word_t                   out_word
);
	import ccdfa_pkg::*;

	// configuration register
	logic [COUNT_W-1:0] exposure_count_q;

	// global pipeline advance
	logic adv;

	// stage 1: word plus registered memory read
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [INDEX_W-1:0]  index_s1;
	frame_role_t         role_s1;
	logic [VALUE_W-1:0]  acc_rd_s1;

	// stage 2: last write-back, kept for forwarding, and divider input
	logic                wr_en_s2;
	logic [ADDR_W-1:0]   wr_addr_s2;
	logic [VALUE_W-1:0]  wr_val_s2;
	div_item_t           div_in_s2;

	// divider output and output register
	div_item_t           div_out;
	logic                out_valid_q;
	out_word_t           out_word_q;

	// stage 1 combinational
	logic [ADDR_W-1:0]   in_addr;
	logic [ADDR_W-1:0]   addr_s1;
	logic                in_range;
	logic [VALUE_W-1:0]  acc_cur;
	logic [VALUE_W:0]    sum_wide;
	logic [VALUE_W-1:0]  sum_sat;
	logic [VALUE_W-1:0]  new_val;
	logic                wr_en_c;
	logic                emit_c;
	div_item_t           div_next;

	// accumulator memory, one entry per pixel
	logic [VALUE_W-1:0]  acc_mem [LINE_PIXELS];

	// hold only when a finished word waits and another result sits right behind it
	assign adv      = !out_valid_q || !out_stall || !div_out.valid;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_count_q <= COUNT_RESET;
		end else if (cfg_wr_en) begin
			exposure_count_q <= cfg_wr_data;
		end
	end

	assign in_addr = ADDR_W'(in_word.pixel_index);
	assign addr_s1 = ADDR_W'(index_s1);

	// read issued as the word is accepted, write-back as it leaves stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_rd_s1 <= acc_mem[in_addr];
			if (wr_en_c) begin
				acc_mem[addr_s1] <= new_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= in_word.pixel_sample;
			index_s1  <= in_word.pixel_index;
			role_s1   <= in_word.frame_role;
		end
	end

	always_comb begin
		in_range = 32'(index_s1) < LINE_PIXELS;
		// the word ahead wrote this entry at the edge that issued our read
		if (wr_en_s2 && (wr_addr_s2 == addr_s1)) begin
			acc_cur = wr_val_s2;
		end else begin
			acc_cur = acc_rd_s1;
		end
		sum_wide = {1'b0, acc_cur} + (VALUE_W + 1)'(sample_s1);
		sum_sat  = sum_wide[VALUE_W] ? SUM_MAX : sum_wide[VALUE_W-1:0];
		new_val  = (role_s1 == ROLE_FIRST) ? VALUE_W'(sample_s1) : sum_sat;
		wr_en_c  = valid_s1 && in_range && (role_s1 != ROLE_PASS);
		emit_c   = valid_s1 && ((role_s1 == ROLE_PASS) || ((role_s1 == ROLE_LAST) && in_range));

		div_next          = '0;
		div_next.valid    = emit_c;
		div_next.position = index_s1;
		if (role_s1 == ROLE_PASS) begin
			div_next.work    = VALUE_W'(sample_s1);
			div_next.divisor = COUNT_W'(1);
		end else begin
			div_next.work    = sum_sat;
			// zero count means no averaging
			div_next.divisor = (exposure_count_q == '0) ? COUNT_W'(1) : exposure_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s2  <= 1'b0;
			div_in_s2 <= '0;
		end else if (adv) begin
			wr_en_s2  <= wr_en_c;
			div_in_s2 <= div_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_addr_s2 <= addr_s1;
			wr_val_s2  <= new_val;
		end
	end

	ccdfa_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    (div_in_s2),
		.dout   (div_out)
	);

	// output register, loads whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= div_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_word_q.pixel_value    <= div_out.work;
			out_word_q.pixel_position <= div_out.position;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
